/* rtl/psh_pkg.sv */
package psh_pkg;

  localparam int CHANNELS  = 16;
  localparam int TIME_BITS = 48;
  localparam int CH_W      = 4;

  typedef logic [TIME_BITS-1:0] time_t;
  localparam time_t TIME_MAX = '1;

  localparam logic [9:0]  RUN_MAX   = 10'd1023;
  localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_REPLY  = 2'd1;
  localparam logic [1:0] OP_FAIL   = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [1:0] HEALTH_UNKNOWN = 2'd0;
  localparam logic [1:0] HEALTH_GOOD    = 2'd1;
  localparam logic [1:0] HEALTH_BAD     = 2'd2;

  localparam logic KIND_SEND   = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  localparam logic [2:0] REG_INTERVAL  = 3'd0;
  localparam logic [2:0] REG_TIMEOUT   = 3'd1;
  localparam logic [2:0] REG_THRESHOLD = 3'd2;
  localparam logic [2:0] REG_SENS      = 3'd3;
  localparam logic [2:0] REG_SLACK     = 3'd4;
  localparam logic [2:0] REG_ENABLE    = 3'd5;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [47:0] now_us;
    logic [3:0]  channel;
    logic [15:0] reply_seq;
    logic [47:0] reply_sent_us;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [3:0]  out_channel;
    logic [15:0] out_seq;
    logic [1:0]  health;
    logic        health_changed;
    logic        rtt_valid;
    logic [47:0] rtt_us;
    logic [31:0] sent_total;
    logic [31:0] received_total;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [31:0] interval;
    logic [25:0] timeout;
    logic [25:0] threshold;
    logic [9:0]  sens;
    logic [19:0] slack;
    logic [15:0] enable;
  } cfg_t;

  typedef struct packed {
    logic        pend;
    logic [15:0] pseq;
    time_t       deadline;
    time_t       nst;
    logic [15:0] seqc;
    logic [1:0]  health;
    logic [9:0]  good_run;
    logic [9:0]  bad_run;
    logic [31:0] samples;
    logic [31:0] replies;
  } entry_t;

  typedef enum logic [1:0] {EV_LOST, EV_SEND, EV_REPLY, EV_FAIL} ev_mode_t;

  // saturating a + b at TIME_MAX
  function automatic time_t sat_add(time_t a, logic [31:0] b);
    logic [TIME_BITS:0] s;
    s = {1'b0, a} + {{(TIME_BITS + 1 - 32){1'b0}}, b};
    return (s >= {1'b0, TIME_MAX}) ? TIME_MAX : s[TIME_BITS-1:0];
  endfunction

endpackage

/* rtl/psh_mem.sv */
module psh_mem (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   we,
  input  logic [psh_pkg::CH_W-1:0] waddr,
  input  psh_pkg::entry_t        wdata,
  input  logic [psh_pkg::CH_W-1:0] raddr,
  output psh_pkg::entry_t        rdata
);
  import psh_pkg::*;

  entry_t               mem [CHANNELS];
  logic [CHANNELS-1:0]  valid;
  entry_t               rd_q;
  logic                 rd_valid;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[raddr];
  end

  // never-written entries read as the reset value (all zero)
  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (we) begin
        valid[waddr] <= 1'b1;
      end
      rd_valid <= valid[raddr];
    end
  end

  assign rdata = rd_valid ? rd_q : '0;

endmodule

/* rtl/psh_eval.sv */
module psh_eval (
  input  psh_pkg::ev_mode_t  mode,
  input  psh_pkg::entry_t    cur,
  input  psh_pkg::cfg_t      cfg,
  input  psh_pkg::time_t     now,
  input  logic [psh_pkg::TIME_BITS:0] now_slack,
  input  logic [47:0]        rtt,
  input  logic [15:0]        rseq,
  input  logic [3:0]         ch,
  output logic               fire,
  output psh_pkg::entry_t    nxt,
  output psh_pkg::out_item_t res
);
  import psh_pkg::*;

  logic        received;
  logic        good;
  entry_t      smp;
  time_t       nst_step;
  logic [15:0] seq_new;
  logic        due_dl;
  logic        due_nst;

  assign received = (mode == EV_REPLY);
  assign good     = received && (rtt <= {22'd0, cfg.threshold});
  assign due_dl   = {1'b0, cur.deadline} <= now_slack;
  assign due_nst  = {1'b0, cur.nst} <= now_slack;
  assign nst_step = sat_add(cur.nst, cfg.interval);
  assign seq_new  = cur.seqc + 16'd1;

  // sample update: counts, streaks, hysteresis
  always_comb begin
    smp      = cur;
    smp.pend = 1'b0;
    if (cur.samples != COUNT_MAX) smp.samples = cur.samples + 32'd1;
    if (received && cur.replies != COUNT_MAX) smp.replies = cur.replies + 32'd1;
    if (good) begin
      if (cur.good_run != RUN_MAX) smp.good_run = cur.good_run + 10'd1;
      smp.bad_run = '0;
    end else begin
      if (cur.bad_run != RUN_MAX) smp.bad_run = cur.bad_run + 10'd1;
      smp.good_run = '0;
    end
    case (cur.health)
      HEALTH_UNKNOWN: smp.health = good ? HEALTH_GOOD : HEALTH_BAD;
      HEALTH_GOOD:    smp.health = (smp.bad_run > cfg.sens) ? HEALTH_BAD : HEALTH_GOOD;
      HEALTH_BAD:     smp.health = (smp.good_run > cfg.sens) ? HEALTH_GOOD : HEALTH_BAD;
      default:        smp.health = good ? HEALTH_GOOD : HEALTH_BAD;
    endcase
  end

  always_comb begin
    fire = 1'b0;
    nxt  = smp;
    res.kind           = KIND_SAMPLE;
    res.out_channel    = ch;
    res.out_seq        = cur.pseq;
    res.health         = smp.health;
    res.health_changed = (smp.health != cur.health);
    res.rtt_valid      = received;
    res.rtt_us         = received ? rtt : '0;
    res.sent_total     = smp.samples;
    res.received_total = smp.replies;
    res.last           = 1'b0;
    case (mode)
      EV_LOST: begin
        fire = cur.pend && due_dl;
      end
      EV_REPLY: begin
        fire = cur.pend && (cur.pseq == rseq);
        res.out_seq = rseq;
      end
      EV_FAIL: begin
        fire = 1'b1;
        res.out_seq = cur.seqc;
      end
      EV_SEND: begin
        fire         = !cur.pend && due_nst;
        nxt          = cur;
        nxt.pend     = 1'b1;
        nxt.seqc     = seq_new;
        nxt.pseq     = seq_new;
        nxt.deadline = sat_add(now, {6'd0, cfg.timeout});
        nxt.nst      = (nst_step <= now) ? sat_add(now, cfg.interval) : nst_step;
        res.kind           = KIND_SEND;
        res.out_seq        = seq_new;
        res.health         = cur.health;
        res.health_changed = 1'b0;
        res.rtt_valid      = 1'b0;
        res.rtt_us         = '0;
        res.sent_total     = cur.samples;
        res.received_total = cur.replies;
      end
      default: fire = 1'b0;
    endcase
  end

endmodule

/* rtl/probe_scheduler_health_hysteresis.sv */
// Liveness probe scheduler for 16 channels. Per-channel state (pending probe,
// deadline, next send time, sequence, health, streaks, counts) sits in one
// 16-entry synchronous memory with a registered read; a sequencer reads
// an entry, applies the lost-probe check, the send check, a reply or a send
// failure, and writes the entry back. A tick walks all channels in order:
// a disabled channel is skipped in the read state, an enabled one passes
// through read, load, lost check, send check and write back, and a finish
// state ends the tick; a reply or send failure passes through read, load,
// its own step, write back and finish (straight to finish when its channel
// is disabled or the opcode is unknown). An output stall holds the sequencer
// only once both the output register and the holding stage are full.
// Results pass through a one-deep holding stage so that the final result
// of an input can carry last; the output register lets a new input be
// taken while the final result still waits. Configuration is a plain write
// port (cfg_we, cfg_index, cfg_data) and must only be written while the
// block is idle. After reset all channels are idle with unknown health, and
// the first tick that finds a channel enabled sends its first probe.
module probe_scheduler_health_hysteresis (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  psh_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output psh_pkg::out_item_t out_item,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import psh_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_LOAD, S_LOST, S_SEND, S_REPLY, S_FAIL, S_WB, S_FIN
  } state_t;

  state_t             state;
  cfg_t               cfg;
  logic [1:0]         op;
  time_t              now;
  logic [TIME_BITS:0] now_slack;
  logic [47:0]        rtt;
  logic [15:0]        rseq;
  logic [CH_W-1:0]    c;
  entry_t             w;
  entry_t             rdata;
  out_item_t          hold;
  out_item_t          hold_final;
  logic               hold_valid;
  logic               slot_free;
  logic               can_emit;
  logic               out_load;
  ev_mode_t           mode;
  logic               fire;
  entry_t             nxt;
  out_item_t          res;
  logic               step_done;
  state_t             step_next;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.interval  <= 32'd1000000;
      cfg.timeout   <= 26'd1000000;
      cfg.threshold <= 26'd1000;
      cfg.sens      <= 10'd3;
      cfg.slack     <= 20'd2000;
      cfg.enable    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_INTERVAL:  cfg.interval  <= cfg_data;
        REG_TIMEOUT:   cfg.timeout   <= cfg_data[25:0];
        REG_THRESHOLD: cfg.threshold <= cfg_data[25:0];
        REG_SENS:      cfg.sens      <= cfg_data[9:0];
        REG_SLACK:     cfg.slack     <= cfg_data[19:0];
        REG_ENABLE:    cfg.enable    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  psh_mem u_mem (
    .clk   (clk),
    .rst   (rst),
    .we    (state == S_WB),
    .waddr (c),
    .wdata (w),
    .raddr (c),
    .rdata (rdata)
  );

  always_comb begin
    case (state)
      S_SEND:  mode = EV_SEND;
      S_REPLY: mode = EV_REPLY;
      S_FAIL:  mode = EV_FAIL;
      default: mode = EV_LOST;
    endcase
  end

  psh_eval u_eval (
    .mode      (mode),
    .cur       (w),
    .cfg       (cfg),
    .now       (now),
    .now_slack (now_slack),
    .rtt       (rtt),
    .rseq      (rseq),
    .ch        (c),
    .fire      (fire),
    .nxt       (nxt),
    .res       (res)
  );

  assign in_ready  = (state == S_IDLE);
  // output register is free after this edge
  assign slot_free = !out_valid || out_ready;
  // a new result may enter the holding stage
  assign can_emit  = !hold_valid || slot_free;
  assign step_done = !fire || can_emit;
  // held result moves into the output register this edge
  assign out_load  = hold_valid && can_emit &&
                     ((fire && (state inside {S_LOST, S_SEND, S_REPLY, S_FAIL})) ||
                      state == S_FIN);

  // held result tagged as the final one of its input
  always_comb begin
    hold_final      = hold;
    hold_final.last = 1'b1;
  end

  always_comb begin
    case (state)
      S_LOST:  step_next = S_SEND;
      default: step_next = S_WB;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      hold_valid <= 1'b0;
    end else begin
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op        <= in_item.opcode;
            now       <= in_item.now_us;
            now_slack <= {1'b0, in_item.now_us} + {{(TIME_BITS - 19){1'b0}}, cfg.slack};
            rtt       <= (in_item.now_us > in_item.reply_sent_us) ?
                         in_item.now_us - in_item.reply_sent_us : '0;
            rseq      <= in_item.reply_seq;
            case (in_item.opcode)
              OP_TICK: begin
                c     <= '0;
                state <= S_RD;
              end
              OP_REPLY, OP_FAIL: begin
                c     <= in_item.channel;
                state <= cfg.enable[in_item.channel] ? S_RD : S_FIN;
              end
              default: state <= S_FIN;
            endcase
          end
        end
        S_RD: begin
          // ticks skip disabled channels without touching the memory
          if (op == OP_TICK && !cfg.enable[c]) begin
            if (c == CH_W'(CHANNELS - 1)) state <= S_FIN;
            else c <= c + 1'b1;
          end else begin
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          w <= rdata;
          case (op)
            OP_TICK:  state <= S_LOST;
            OP_REPLY: state <= S_REPLY;
            default:  state <= S_FAIL;
          endcase
        end
        S_LOST, S_SEND, S_REPLY, S_FAIL: begin
          if (step_done) begin
            if (fire) begin
              // held results are never final here, last is already clear
              if (hold_valid) begin
                out_item <= hold;
              end
              hold       <= res;
              hold_valid <= 1'b1;
              w          <= nxt;
            end
            state <= step_next;
          end
        end
        S_WB: begin
          if (op == OP_TICK && c != CH_W'(CHANNELS - 1)) begin
            c     <= c + 1'b1;
            state <= S_RD;
          end else begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          // flush the held result as the final one of this input
          if (can_emit) begin
            if (hold_valid) begin
              out_item   <= hold_final;
              hold_valid <= 1'b0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
